FILE: rtl/otf_pkg.sv
// Shared constants, types and the gray conversion for the Otsu threshold finder.
`timescale 1ns / 1ps
package otf_pkg;

    localparam int GRAY_BINS      = 256;
    localparam int GRAY_AW        = $clog2(GRAY_BINS);
    localparam int DEF_COUNT_BITS = 24;
    localparam int TOTAL_W        = 25;

    typedef struct packed {
        logic               we;
        logic [GRAY_AW-1:0] waddr;
        logic [GRAY_AW-1:0] raddr;
    } hist_req_t;

    // round((r+g+b)/3): (s*683)>>11 is exact floor(s/3) for s below 2047
    function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        logic [9:0]  s;
        logic [20:0] p;
        s = {2'b00, r} + {2'b00, g} + {2'b00, b} + 10'd1;
        p = {11'd0, s} * 21'd683;
        return p[18:11];
    endfunction

endpackage

FILE: rtl/otf_hist.sv
// Gray level histogram memory, one write and one registered read port.
`timescale 1ns / 1ps
module otf_hist #(
    parameter int WC = otf_pkg::DEF_COUNT_BITS + 1
) (
    input  logic               aclk,
    input  otf_pkg::hist_req_t req,
    input  logic [WC-1:0]      wdata,
    output logic [WC-1:0]      rdata
);
    import otf_pkg::*;

    logic [WC-1:0] mem [GRAY_BINS];
    logic [WC-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/otf_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module otf_mul #(
    parameter int WA = 64,
    parameter int WB = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [WA-1:0] a,
    input  logic [WB-1:0] b,
    output logic          busy,
    output logic          done,
    output logic [WA-1:0] product
);
    import otf_pkg::*;

    logic [WA-1:0] acc_reg, a_reg;
    logic [WB-1:0] b_reg;
    logic          busy_reg, done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (b_reg == '0)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end else if (busy_reg && (b_reg != '0)) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("multiplier restarted while busy");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("done while still busy");

endmodule

FILE: rtl/otsu_threshold_finder_unit.sv
// Otsu threshold finder: pixel histogram, threshold search sequencer and result register.
// Usage:
//   Input channel s_*: one RGB pixel per item; s_last_pixel marks the frame's final pixel.
//   Each pixel is converted to gray round((r+g+b)/3) and counted into a 256-bin histogram.
//   Result channel m_*: one item per frame, issued after the last pixel: threshold,
//   pixel_total (saturating count) and count_saturated.
//   Pixel handling: each pixel is a histogram read, then a write back to the same bin;
//   s_ready is low during the write back, so the next pixel waits until it is done.
//   Search after the last pixel: a totals pass reads all 256 bins, then each of the
//   256 levels is scanned; a level with both classes non-empty runs a chain of
//   products on the shared shift-add multiplier, one multiplier bit per cycle.
//   Reset: a clearing pass over all 256 bins empties the histogram; s_ready stays low.
//   The histogram is cleared during each search, so no pass is needed between frames.
//   Stall: the result is held in a register; pixels of the next frame are accepted
//   while it waits, but the next search cannot issue its result until it is taken.
`timescale 1ns / 1ps
module otsu_threshold_finder_unit #(
    parameter int COUNT_BITS = otf_pkg::DEF_COUNT_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_red,
    input  logic [7:0]                   s_green,
    input  logic [7:0]                   s_blue,
    input  logic                         s_last_pixel,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [7:0]                   m_threshold,
    output logic [otf_pkg::TOTAL_W-1:0]  m_pixel_total,
    output logic                         m_count_saturated
);
    import otf_pkg::*;

    localparam int WC  = COUNT_BITS + 1;
    localparam int WW  = COUNT_BITS + 9;
    localparam int WM  = COUNT_BITS + 17;
    localparam int WD  = WW + WM;
    localparam int WN  = 2 * WD;
    localparam int WE  = 2 * WW;
    localparam int WX  = WN + WE;
    localparam int WEX = (WC > TOTAL_W) ? WC : TOTAL_W;
    localparam logic [WC-1:0] COUNT_MAX = WC'(1) << COUNT_BITS;

    typedef enum logic [14:0] {
        ST_CLEAR   = 15'b000000000000001,
        ST_IDLE    = 15'b000000000000010,
        ST_PIX_WR  = 15'b000000000000100,
        ST_SUM_RD  = 15'b000000000001000,
        ST_SUM_ACC = 15'b000000000010000,
        ST_SCN_RD  = 15'b000000000100000,
        ST_SCN_ACC = 15'b000000001000000,
        ST_MUL_X   = 15'b000000010000000,
        ST_MUL_Y   = 15'b000000100000000,
        ST_MUL_NUM = 15'b000001000000000,
        ST_MUL_DEN = 15'b000010000000000,
        ST_MUL_L   = 15'b000100000000000,
        ST_MUL_R   = 15'b001000000000000,
        ST_NEXT    = 15'b010000000000000,
        ST_DONE    = 15'b100000000000000
    } state_t;

    state_t          state_reg;
    logic [7:0]      t_reg, best_t_reg, gray_reg;
    logic            last_reg, go_reg, flag_reg;
    logic [WC-1:0]   cnt_reg;
    logic [WW-1:0]   wt_reg, w1_reg;
    logic [WM-1:0]   mt_reg, m1_reg;
    logic [WD-1:0]   x_reg;
    logic [WN-1:0]   num_reg, bnum_reg;
    logic [WE-1:0]   den_reg, bden_reg;
    logic [WX-1:0]   lhs_reg;
    logic            m_valid_reg, m_sat_reg;
    logic [7:0]      m_thr_reg;
    logic [TOTAL_W-1:0] m_tot_reg;

    hist_req_t       hreq;
    logic [WC-1:0]   hwdata, hrdata, bin_inc;
    logic            bin_sat;
    logic [WC+7:0]   th;
    logic [WW-1:0]   w1_new, w2;
    logic [WM-1:0]   m1_new, m2;
    logic            mul_busy, mul_done;
    logic [WX-1:0]   mul_a, mul_p;
    logic [WD-1:0]   mul_b, diff;
    logic [WEX-1:0]  cnt_ext;
    logic            out_free;

    otf_hist #(.WC(WC)) u_hist (
        .aclk  (aclk),
        .req   (hreq),
        .wdata (hwdata),
        .rdata (hrdata)
    );

    otf_mul #(.WA(WX), .WB(WD)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (go_reg),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_p)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign th       = t_reg * hrdata;
    assign w1_new   = w1_reg + WW'(hrdata);
    assign m1_new   = m1_reg + WM'(th);
    assign w2       = wt_reg - w1_reg;
    assign m2       = mt_reg - m1_reg;
    assign diff     = (x_reg >= mul_p[WD-1:0]) ? (x_reg - mul_p[WD-1:0])
                                               : (mul_p[WD-1:0] - x_reg);
    assign bin_sat  = (hrdata >= COUNT_MAX - WC'(1));
    assign bin_inc  = bin_sat ? COUNT_MAX : (hrdata + WC'(1));
    assign cnt_ext  = WEX'(cnt_reg);

    always_comb begin
        hreq.we    = 1'b0;
        hreq.waddr = t_reg;
        hreq.raddr = t_reg;
        hwdata     = '0;
        unique case (state_reg)
            ST_CLEAR:  hreq.we = 1'b1;
            ST_IDLE:   hreq.raddr = gray_of(s_red, s_green, s_blue);
            ST_PIX_WR: begin
                hreq.we    = 1'b1;
                hreq.waddr = gray_reg;
                hwdata     = bin_inc;
            end
            ST_SCN_RD: hreq.we = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_X: begin
                mul_a = WX'(m1_reg);
                mul_b = WD'(w2);
            end
            ST_MUL_Y: begin
                mul_a = WX'(m2);
                mul_b = WD'(w1_reg);
            end
            ST_MUL_NUM: begin
                mul_a = WX'(x_reg);
                mul_b = x_reg;
            end
            ST_MUL_DEN: begin
                mul_a = WX'(w1_reg);
                mul_b = WD'(w2);
            end
            ST_MUL_L: begin
                mul_a = WX'(num_reg);
                mul_b = WD'(bden_reg);
            end
            ST_MUL_R: begin
                mul_a = WX'(bnum_reg);
                mul_b = WD'(den_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            t_reg       <= '0;
            go_reg      <= 1'b0;
            cnt_reg     <= '0;
            flag_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            best_t_reg  <= '0;
        end else begin
            go_reg <= 1'b0;
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    t_reg <= t_reg + 8'd1;
                    if (t_reg == 8'hFF) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        gray_reg  <= gray_of(s_red, s_green, s_blue);
                        last_reg  <= s_last_pixel;
                        state_reg <= ST_PIX_WR;
                    end
                end
                ST_PIX_WR: begin
                    if (bin_sat || (cnt_reg >= COUNT_MAX - WC'(1))) begin
                        flag_reg <= 1'b1;
                    end
                    cnt_reg <= (cnt_reg >= COUNT_MAX - WC'(1)) ? COUNT_MAX
                                                               : cnt_reg + WC'(1);
                    t_reg   <= '0;
                    wt_reg  <= '0;
                    mt_reg  <= '0;
                    state_reg <= last_reg ? ST_SUM_RD : ST_IDLE;
                end
                ST_SUM_RD: state_reg <= ST_SUM_ACC;
                ST_SUM_ACC: begin
                    wt_reg <= wt_reg + WW'(hrdata);
                    mt_reg <= mt_reg + WM'(th);
                    t_reg  <= t_reg + 8'd1;
                    if (t_reg == 8'hFF) begin
                        w1_reg     <= '0;
                        m1_reg     <= '0;
                        best_t_reg <= '0;
                        state_reg  <= ST_SCN_RD;
                    end else begin
                        state_reg <= ST_SUM_RD;
                    end
                end
                ST_SCN_RD: state_reg <= ST_SCN_ACC;
                ST_SCN_ACC: begin
                    w1_reg <= w1_new;
                    m1_reg <= m1_new;
                    if ((w1_new == '0) || (w1_new == wt_reg)) begin
                        if (t_reg == 8'd0) begin
                            bnum_reg <= '0;
                            bden_reg <= WE'(1);
                        end
                        state_reg <= ST_NEXT;
                    end else begin
                        go_reg    <= 1'b1;
                        state_reg <= ST_MUL_X;
                    end
                end
                ST_MUL_X: begin
                    if (mul_done) begin
                        x_reg     <= mul_p[WD-1:0];
                        go_reg    <= 1'b1;
                        state_reg <= ST_MUL_Y;
                    end
                end
                ST_MUL_Y: begin
                    if (mul_done) begin
                        x_reg     <= diff;
                        go_reg    <= 1'b1;
                        state_reg <= ST_MUL_NUM;
                    end
                end
                ST_MUL_NUM: begin
                    if (mul_done) begin
                        num_reg   <= mul_p[WN-1:0];
                        go_reg    <= 1'b1;
                        state_reg <= ST_MUL_DEN;
                    end
                end
                ST_MUL_DEN: begin
                    if (mul_done) begin
                        den_reg <= mul_p[WE-1:0];
                        if (t_reg == 8'd0) begin
                            bnum_reg  <= num_reg;
                            bden_reg  <= mul_p[WE-1:0];
                            state_reg <= ST_NEXT;
                        end else begin
                            go_reg    <= 1'b1;
                            state_reg <= ST_MUL_L;
                        end
                    end
                end
                ST_MUL_L: begin
                    if (mul_done) begin
                        lhs_reg   <= mul_p;
                        go_reg    <= 1'b1;
                        state_reg <= ST_MUL_R;
                    end
                end
                ST_MUL_R: begin
                    if (mul_done) begin
                        if (lhs_reg > mul_p) begin
                            best_t_reg <= t_reg;
                            bnum_reg   <= num_reg;
                            bden_reg   <= den_reg;
                        end
                        state_reg <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    if (t_reg == 8'hFF) begin
                        state_reg <= ST_DONE;
                    end else begin
                        t_reg     <= t_reg + 8'd1;
                        state_reg <= ST_SCN_RD;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_thr_reg   <= best_t_reg;
                        m_tot_reg   <= cnt_ext[TOTAL_W-1:0];
                        m_sat_reg   <= flag_reg;
                        cnt_reg     <= '0;
                        flag_reg    <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_CLEAR;
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_threshold       = m_thr_reg;
    assign m_pixel_total     = m_tot_reg;
    assign m_count_saturated = m_sat_reg;

    a_best_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL_X) |-> (best_t_reg <= t_reg))
        else $error("best level ahead of scan");
    a_class_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL_X) |-> ((w1_reg != '0) && (w1_reg < wt_reg)))
        else $error("multiplying with an empty class");
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= COUNT_MAX) else $error("pixel count above cap");
    a_go_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        go_reg |-> !mul_busy) else $error("multiplier started while busy");

endmodule
